FILE: rtl/psfs_pkg.sv
// shared types and constants for the pad state frame sender
package psfs_pkg;

	localparam int ElapsedBits = 16;
	localparam int CmpBits     = (ElapsedBits > 16) ? ElapsedBits : 16;
	localparam int FrameLen    = 13;
	localparam int LastIdx     = FrameLen - 1;
	localparam int IdxBits     = $clog2(FrameLen);
	localparam int QueueDepth  = 2;
	localparam int PtrBits     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CountBits   = $clog2(QueueDepth + 1);
	localparam int CfgIdxBits  = 2;
	localparam int CfgDataBits = 16;

	localparam logic [7:0] SyncA    = 8'hA5;
	localparam logic [7:0] SyncB    = 8'h5A;
	localparam logic [7:0] StickMid = 8'h80;

	localparam logic        LinkReset   = 1'b1;
	localparam logic [15:0] AnalogReset = 16'd8;
	localparam logic [15:0] HeartReset  = 16'd200;

	typedef enum logic [1:0] {
		MODE_STATE = 2'd0,
		MODE_IDLE  = 2'd1,
		MODE_TICK  = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxBits-1:0] {
		CFG_LINK   = 2'd0,
		CFG_ANALOG = 2'd1,
		CFG_HEART  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic        link_enabled;
		logic [15:0] analog_interval_ms;
		logic [15:0] heartbeat_ms;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  chk;
		logic [7:0]  seq;
		logic [47:0] analog;
		logic [23:0] buttons;
	} frame_desc_t;

	typedef struct packed {
		logic        push;
		frame_desc_t desc;
	} q_wr_t;

	typedef struct packed {
		logic        valid;
		frame_desc_t desc;
	} q_rd_t;

endpackage

FILE: rtl/psfs_if.sv
// request channels of the pad state frame sender
interface psfs_pad_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [23:0] button_map;
	logic [7:0]  left_x;
	logic [7:0]  left_y;
	logic [7:0]  right_x;
	logic [7:0]  right_y;
	logic [7:0]  left_trigger;
	logic [7:0]  right_trigger;

	modport source (output valid, mode, button_map, left_x, left_y, right_x, right_y,
		left_trigger, right_trigger, input ready);
	modport sink (input valid, mode, button_map, left_x, left_y, right_x, right_y,
		left_trigger, right_trigger, output ready);
endinterface

interface psfs_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, frame_byte, frame_end, input ready);
	modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

FILE: rtl/pad_state_frame_sender.sv
// top level of the pad state frame sender
//
//  channel | dir | request                               | handshake
//  pad     | in  | mode, button map, sticks, triggers    | valid / ready
//  frame   | out | frame_byte, frame_end                 | valid / ready
//  cfg     | in  | cfg_index, cfg_data                   | cfg_we, no wait
//
//  one request accepted per cycle while the queue has room; ticks and
//  suppressed requests take that single cycle
//  a sent frame occupies the serializer for its 13 bytes, one byte per cycle while the frame sink is ready
//  the two-entry descriptor queue holds frames waiting for the serializer
//  a stalled frame sink stalls pad requests only once the queue fills
//  reset takes effect at once, no clearing pass
module pad_state_frame_sender (
	input  logic                                 clk,
	input  logic                                 arst_n,
	psfs_pad_if.sink                             pad,
	psfs_frame_if.source                         frame,
	input  logic                                 cfg_we,
	input  logic [psfs_pkg::CfgIdxBits-1:0]      cfg_index,
	input  logic [psfs_pkg::CfgDataBits-1:0]     cfg_data
);
	import psfs_pkg::*;

	cfg_t  cfg_q;
	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_enabled       <= LinkReset;
			cfg_q.analog_interval_ms <= AnalogReset;
			cfg_q.heartbeat_ms       <= HeartReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINK:   cfg_q.link_enabled       <= cfg_data[0];
				CFG_ANALOG: cfg_q.analog_interval_ms <= cfg_data;
				CFG_HEART:  cfg_q.heartbeat_ms       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	psfs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pad    (pad),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	psfs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.pop    (pop),
		.q_rd   (q_rd)
	);

	psfs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rd   (q_rd),
		.pop    (pop),
		.frame  (frame)
	);

endmodule

FILE: rtl/psfs_front.sv
// front end: accepts requests, keeps the send state and decides on frames
module psfs_front (
	input  logic              clk,
	input  logic              arst_n,
	psfs_pad_if.sink          pad,
	input  psfs_pkg::cfg_t    cfg,
	input  logic              q_full,
	output psfs_pkg::q_wr_t   q_wr
);
	import psfs_pkg::*;

	logic [23:0]            prev_buttons_q;
	logic [47:0]            prev_analog_q;
	logic [7:0]             seq_q;
	logic                   sent_once_q;
	logic [ElapsedBits-1:0] elapsed_q;

	logic                   accept;
	logic                   is_state;
	logic                   is_idle;
	logic                   is_tick;
	logic                   emit;
	logic [23:0]            btn;
	logic [47:0]            ana;
	logic [CmpBits-1:0]     el_ext;
	logic                   analog_due;
	logic                   heart_due;

	assign pad.ready = !q_full;
	assign accept    = pad.valid && pad.ready;

	assign is_state = (pad.mode == MODE_STATE);
	assign is_idle  = (pad.mode == MODE_IDLE);
	assign is_tick  = (pad.mode == MODE_TICK);

	assign el_ext     = CmpBits'(elapsed_q);
	assign analog_due = el_ext >= CmpBits'(cfg.analog_interval_ms);
	assign heart_due  = el_ext >= CmpBits'(cfg.heartbeat_ms);

	always_comb begin
		if (is_idle) begin
			btn = '0;
			ana = {8'h00, 8'h00, StickMid, StickMid, StickMid, StickMid};
		end else begin
			btn = pad.button_map;
			ana = {pad.right_trigger, pad.left_trigger, pad.right_y, pad.right_x,
				pad.left_y, pad.left_x};
		end
	end

	assign emit = cfg.link_enabled && (is_idle || (is_state && (!sent_once_q ||
		(btn != prev_buttons_q) || ((ana != prev_analog_q) && analog_due) || heart_due)));

	always_comb begin
		q_wr.push         = accept && emit;
		q_wr.desc.buttons = btn;
		q_wr.desc.analog  = ana;
		q_wr.desc.seq     = seq_q;
		q_wr.desc.chk     = btn[7:0] ^ btn[15:8] ^ btn[23:16] ^ ana[7:0] ^ ana[15:8] ^
			ana[23:16] ^ ana[31:24] ^ ana[39:32] ^ ana[47:40] ^ seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_buttons_q <= '0;
			prev_analog_q  <= '0;
			seq_q          <= '0;
			sent_once_q    <= 1'b0;
			elapsed_q      <= '0;
		end else if (accept) begin
			if (is_tick) begin
				if (elapsed_q != '1)
					elapsed_q <= elapsed_q + 1'b1;
			end else if (emit) begin
				prev_buttons_q <= btn;
				prev_analog_q  <= ana;
				seq_q          <= seq_q + 8'd1;
				sent_once_q    <= 1'b1;
				elapsed_q      <= '0;
			end
		end
	end

`ifndef SYNTH
	a_emit_clears_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |=> (elapsed_q == '0) && sent_once_q)
		else $error("elapsed time not cleared after a frame");
`endif

endmodule

FILE: rtl/psfs_queue.sv
// short frame descriptor queue between front and back
module psfs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  psfs_pkg::q_wr_t  q_wr,
	output logic             q_full,
	input  logic             pop,
	output psfs_pkg::q_rd_t  q_rd
);
	import psfs_pkg::*;

	frame_desc_t            entries_q [QueueDepth];
	logic [PtrBits-1:0]     wr_ptr_q;
	logic [PtrBits-1:0]     rd_ptr_q;
	logic [CountBits-1:0]   count_q;
	logic                   do_pop;

	assign q_full     = (count_q == CountBits'(QueueDepth));
	assign q_rd.valid = (count_q != '0);
	assign q_rd.desc  = entries_q[rd_ptr_q];
	assign do_pop     = pop && q_rd.valid;

	always_ff @(posedge clk) begin
		if (q_wr.push)
			entries_q[wr_ptr_q] <= q_wr.desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push)
				wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (q_wr.push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!q_wr.push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_full || do_pop)
		else $error("push into a full queue");
`endif

endmodule

FILE: rtl/psfs_back.sv
// back end: serializes one frame descriptor into thirteen bytes
module psfs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  psfs_pkg::q_rd_t  q_rd,
	output logic             pop,
	psfs_frame_if.source     frame
);
	import psfs_pkg::*;

	frame_desc_t              desc_q;
	logic                     busy_q;
	logic [IdxBits-1:0]       cnt_q;
	logic                     out_valid_q;
	logic [7:0]               byte_q;
	logic                     end_q;

	logic                     adv;
	logic                     last;
	logic [FrameLen-1:0][7:0] frame_bytes;

	assign adv  = !out_valid_q || frame.ready;
	assign last = (cnt_q == IdxBits'(LastIdx));
	assign pop  = q_rd.valid && (!busy_q || (adv && last));

	assign frame_bytes = {desc_q.chk, desc_q.seq, desc_q.analog, desc_q.buttons, SyncB, SyncA};

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = byte_q;
	assign frame.frame_end  = end_q;

	always_ff @(posedge clk) begin
		if (pop)
			desc_q <= q_rd.desc;
		if (adv && busy_q) begin
			byte_q <= frame_bytes[cnt_q];
			end_q  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv)
				out_valid_q <= busy_q;
			if (adv && busy_q) begin
				cnt_q  <= last ? '0 : cnt_q + 1'b1;
				busy_q <= !last;
			end
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IdxBits'(LastIdx))
		else $error("byte index past frame end");
	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0)
		else $error("byte index not cleared while idle");
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && busy_q && last) |=> out_valid_q && end_q)
		else $error("checksum byte not marked as frame end");
`endif

endmodule

FILE: test/pad_state_frame_sender_check.sv
// checker for the pad state frame sender: predicts frame bytes and compares them
`timescale 1ns / 100ps

module pad_state_frame_sender_check (
	input  logic                             clk,
	input  logic                             arst_n,
	psfs_pad_if                              pad,
	psfs_frame_if                            frame,
	input  logic                             cfg_we,
	input  logic [psfs_pkg::CfgIdxBits-1:0]  cfg_index,
	input  logic [psfs_pkg::CfgDataBits-1:0] cfg_data,
	output int unsigned                      mismatches,
	output int unsigned                      bytes_outstanding
);
	import psfs_pkg::*;

	localparam int ReportLimit = 10;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} line_byte_t;

	cfg_t                   link_cfg;
	logic [23:0]            sent_buttons;
	logic [47:0]            sent_analog;
	logic [7:0]             next_seq;
	logic                   any_sent;
	logic [ElapsedBits-1:0] ms_since_frame;
	line_byte_t             bytes_due[$];
	int unsigned            bad;

	task automatic queue_frame(input logic [23:0] buttons, input logic [47:0] analog);
		logic [7:0] body [9];
		logic [7:0] chk;
		for (int i = 0; i < 3; i++)
			body[i] = buttons[8*i +: 8];
		for (int i = 0; i < 6; i++)
			body[3+i] = analog[8*i +: 8];
		chk = next_seq;
		bytes_due.push_back(line_byte_t'{SyncA, 1'b0});
		bytes_due.push_back(line_byte_t'{SyncB, 1'b0});
		for (int i = 0; i < 9; i++) begin
			bytes_due.push_back(line_byte_t'{body[i], 1'b0});
			chk ^= body[i];
		end
		bytes_due.push_back(line_byte_t'{next_seq, 1'b0});
		bytes_due.push_back(line_byte_t'{chk, 1'b1});
		next_seq++;
		sent_buttons = buttons;
		sent_analog = analog;
		ms_since_frame = '0;
		any_sent = 1'b1;
	endtask

	task automatic take_request();
		logic [23:0] buttons;
		logic [47:0] analog;
		logic        old_enough;
		logic        heart_due;
		buttons = pad.button_map;
		analog = {pad.right_trigger, pad.left_trigger, pad.right_y, pad.right_x,
			pad.left_y, pad.left_x};
		old_enough = CmpBits'(ms_since_frame) >= CmpBits'(link_cfg.analog_interval_ms);
		heart_due = CmpBits'(ms_since_frame) >= CmpBits'(link_cfg.heartbeat_ms);
		case (pad.mode)
			MODE_TICK: begin
				if (ms_since_frame != '1)
					ms_since_frame++;
			end
			MODE_IDLE: begin
				if (link_cfg.link_enabled)
					queue_frame(24'h0, {16'h0, {4{StickMid}}});
			end
			MODE_STATE: begin
				if (link_cfg.link_enabled && (!any_sent || buttons != sent_buttons
						|| (analog != sent_analog && old_enough) || heart_due))
					queue_frame(buttons, analog);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_byte();
		line_byte_t got;
		line_byte_t want;
		got = line_byte_t'{frame.frame_byte, frame.frame_end};
		if (bytes_due.size() == 0) begin
			bad++;
			if (bad <= ReportLimit)
				$display("unexpected frame byte %02h end %0b", got.value, got.last);
		end else begin
			want = bytes_due.pop_front();
			if (got.value !== want.value || got.last !== want.last) begin
				bad++;
				if (bad <= ReportLimit)
					$display("frame byte: expected %02h end %0b, got %02h end %0b",
						want.value, want.last, got.value, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_cfg = '{link_enabled: LinkReset, analog_interval_ms: AnalogReset,
				heartbeat_ms: HeartReset};
			sent_buttons = '0;
			sent_analog = '0;
			next_seq = '0;
			any_sent = 1'b0;
			ms_since_frame = '0;
			bytes_due.delete();
			bad = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LINK:   link_cfg.link_enabled = cfg_data[0];
					CFG_ANALOG: link_cfg.analog_interval_ms = cfg_data;
					CFG_HEART:  link_cfg.heartbeat_ms = cfg_data;
					default: begin
					end
				endcase
			end
			if (pad.valid && pad.ready)
				take_request();
			if (frame.valid && frame.ready)
				check_byte();
		end
		mismatches <= bad;
		bytes_outstanding <= bytes_due.size();
	end

endmodule

FILE: test/pad_state_frame_sender_test.sv
// testbench top for the pad state frame sender: stimulus, pacing and verdict
`timescale 1ns / 100ps

module pad_state_frame_sender_test;
	import psfs_pkg::*;

	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam int         SettleCycles = 16;
	localparam int         StallLimit   = 2000;

	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] buttons;
		logic [47:0] analog;
	} pad_req_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CfgIdxBits-1:0]  cfg_index;
	logic [CfgDataBits-1:0] cfg_data;
	int unsigned            mismatches;
	int unsigned            bytes_outstanding;
	logic                   steady;
	pad_req_t               last_state;

	psfs_pad_if   pad ();
	psfs_frame_if frame ();

	pad_state_frame_sender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pad       (pad),
		.frame     (frame),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pad_state_frame_sender_check frame_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.pad               (pad),
		.frame             (frame),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatches        (mismatches),
		.bytes_outstanding (bytes_outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int gap_len();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pad_req_t pad_req(input logic [1:0] mode, input logic [23:0] buttons,
			input logic [47:0] analog);
		pad_req_t req;
		req.mode = mode;
		req.buttons = buttons;
		req.analog = analog;
		return req;
	endfunction

	// mostly small edits of the last state so that suppression paths get exercised
	function automatic pad_req_t next_state();
		pad_req_t req;
		int roll;
		int pick;
		req = last_state;
		req.mode = MODE_STATE;
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
		end else if (roll < 60) begin
			pick = $urandom_range(0, 5);
			req.analog[8*pick +: 8] = 8'($urandom_range(0, 255));
		end else if (roll < 85) begin
			pick = $urandom_range(0, 23);
			req.buttons[pick] = ~req.buttons[pick];
		end else if (roll < 95) begin
			req.buttons = 24'($urandom);
			req.analog = {16'($urandom), 32'($urandom)};
		end else begin
			req.buttons = {24{roll[0]}};
			req.analog = {48{roll[1]}};
		end
		last_state = req;
		return req;
	endfunction

	function automatic pad_req_t random_req();
		pad_req_t req;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 64)
			return next_state();
		req = pad_req(MODE_TICK, 24'($urandom), {16'($urandom), 32'($urandom)});
		if (roll < 78)
			req.mode = MODE_IDLE;
		else if (roll >= 97)
			req.mode = MODE_SPARE;
		return req;
	endfunction

	task automatic put_pad(input pad_req_t req);
		int idle;
		idle = gap_len();
		if (idle > 0) begin
			pad.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		pad.valid <= 1'b1;
		pad.mode <= req.mode;
		pad.button_map <= req.buttons;
		pad.left_x <= req.analog[7:0];
		pad.left_y <= req.analog[15:8];
		pad.right_x <= req.analog[23:16];
		pad.right_y <= req.analog[31:24];
		pad.left_trigger <= req.analog[39:32];
		pad.right_trigger <= req.analog[47:40];
		@(posedge clk);
		while (!pad.ready) @(posedge clk);
	endtask

	task automatic drain();
		pad.valid <= 1'b0;
		@(posedge clk);
		while (bytes_outstanding != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic configure(input logic link, input logic [15:0] analog,
			input logic [15:0] heart);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LINK;
		cfg_data <= {15'd0, link};
		@(posedge clk);
		cfg_index <= CFG_ANALOG;
		cfg_data <= analog;
		@(posedge clk);
		cfg_index <= CFG_HEART;
		cfg_data <= heart;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic link, input logic [15:0] analog,
			input logic [15:0] heart, input int count);
		drain();
		configure(link, analog, heart);
		repeat (count) put_pad(random_req());
	endtask

	// frame sink pacing
	initial begin
		int hold;
		frame.ready = 1'b0;
		forever begin
			hold = gap_len();
			if (hold > 0) begin
				frame.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			frame.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < StallLimit) begin
			@(posedge clk);
			if ((pad.valid && pad.ready) || (frame.valid && frame.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("pad_state_frame_sender: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pad.valid = 1'b0;
		pad.mode = MODE_STATE;
		pad.button_map = '0;
		pad.left_x = '0;
		pad.left_y = '0;
		pad.right_x = '0;
		pad.right_y = '0;
		pad.left_trigger = '0;
		pad.right_trigger = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first frame, suppression, analog interval, heartbeat, idle, spare mode, link disabled
		configure(1'b1, 16'd3, 16'd5);
		put_pad(pad_req(MODE_STATE, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF));
		put_pad(pad_req(MODE_STATE, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF));
		put_pad(pad_req(MODE_STATE, 24'h000000, 48'h0));
		put_pad(pad_req(MODE_STATE, 24'h000000, 48'h0605_0403_0201));
		repeat (3) put_pad(pad_req(MODE_TICK, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF));
		put_pad(pad_req(MODE_STATE, 24'h000000, 48'h0605_0403_0201));
		repeat (5) put_pad(pad_req(MODE_TICK, 24'h0, 48'h0));
		put_pad(pad_req(MODE_STATE, 24'h000000, 48'h0605_0403_0201));
		put_pad(pad_req(MODE_IDLE, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF));
		put_pad(pad_req(MODE_SPARE, 24'h123456, 48'h89AB_CDEF_0123));
		put_pad(pad_req(MODE_STATE, 24'hA5A5A5, 48'h5A5A_5A5A_5A5A));
		drain();
		configure(1'b0, 16'd3, 16'd5);
		put_pad(pad_req(MODE_STATE, 24'h5A5A5A, 48'hA5A5_A5A5_A5A5));
		put_pad(pad_req(MODE_IDLE, 24'h0, 48'h0));
		put_pad(pad_req(MODE_TICK, 24'h0, 48'h0));
		drain();
		configure(1'b1, 16'd0, 16'd0);
		last_state = pad_req(MODE_STATE, 24'hA5A5A5, 48'h5A5A_5A5A_5A5A);
		put_pad(last_state);

		run_phase(1'b1, 16'd3, 16'd10, 40);
		run_phase(1'b1, 16'd0, 16'd0, 50);
		run_phase(1'b0, 16'd5, 16'd20, 25);
		run_phase(1'b1, 16'hFFFF, 16'hFFFF, 30);
		steady = 1'b1;
		run_phase(1'b1, 16'd1, 16'd0, 70);
		steady = 1'b0;
		run_phase(1'b1, 16'($urandom_range(0, 15)), 16'($urandom_range(0, 40)), 40);

		drain();
		if (mismatches == 0 && bytes_outstanding == 0)
			$display("pad_state_frame_sender: match");
		else
			$display("pad_state_frame_sender: mismatch");
		$finish;
	end

endmodule
